FILE: rtl/core/rarmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_pkg
// Shared types, codes and helpers for the range add / range max tree.
// ----------------------------------------------------------------------------
package rarmt_pkg;

    // default tree size
    localparam int LEAVES_DEF = 1024;

    // field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 11;
    localparam int VAL_W  = 48;
    localparam int MAX_W  = 64;
    localparam int NODE_W = 128;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_RAISE  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // value reported for an empty query
    localparam logic [MAX_W-1:0] EMPTY_VAL = 64'hE000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALL,
        ST_EVAL,
        ST_RET,
        ST_RET2,
        ST_PEVAL,
        ST_FIN,
        ST_DONE
    } seq_state_t;

    // signed greater-than on raw 64-bit words
    function automatic logic sgt(input logic [MAX_W-1:0] a, input logic [MAX_W-1:0] b);
        sgt = $signed(a) > $signed(b);
    endfunction

    function automatic logic [MAX_W-1:0] smax(input logic [MAX_W-1:0] a,
                                              input logic [MAX_W-1:0] b);
        smax = sgt(a, b) ? a : b;
    endfunction

endpackage

FILE: rtl/core/range_add_range_max_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_max_tree
// Segment tree with range add, range max query and point raise.
// ----------------------------------------------------------------------------
// After reset the node store is cleared one node per cycle, all 2*LEAVES
// nodes, with s_tready low. Each beat then walks the tree depth first through a
// node store with one read and one write port: a node that is wholly inside
// or outside the range is read, evaluated and returned, and a node that
// splits is read, evaluated, stepped back to after each child, combined and
// returned. A point raise runs a one-leaf query walk and, when it lifts the
// leaf, an add walk on the same path.
// The next beat is taken once the result has moved to the output register.
// ----------------------------------------------------------------------------
module range_add_range_max_tree #(
    parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // op[1:0], left[12:2], right[23:13], value[71:24]
    input  logic [rarmt_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // max_value[63:0]
    output logic [rarmt_pkg::M_DATA_W-1:0]     m_tdata,
    // empty_range[0]
    output logic                               m_tuser
);
    import rarmt_pkg::*;

    localparam int NW = $clog2(2 * LEAVES);

    logic              wr_en;
    logic [NW-1:0]     wr_addr, rd_addr;
    logic [NODE_W-1:0] wr_data, rd_data;
    logic              res_load, res_empty;
    logic [MAX_W-1:0]  res_max;
    logic              mvalid_reg;
    logic [MAX_W-1:0]  mdata_reg;
    logic              muser_reg;

    rarmt_mem #(.LEAVES(LEAVES)) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rarmt_seq #(.LEAVES(LEAVES)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[1:0]),
        .in_left   (s_tdata[12:2]),
        .in_right  (s_tdata[23:13]),
        .in_value  (s_tdata[71:24]),
        .out_free  (!mvalid_reg || m_tready),
        .res_load  (res_load),
        .res_max   (res_max),
        .res_empty (res_empty),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (res_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            mdata_reg <= res_max;
            muser_reg <= res_empty;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

FILE: rtl/core/rarmt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_mem
// Node store: one write port, one read port with registered read data.
// Each word is {pending add, subtree best}.
// ----------------------------------------------------------------------------
module rarmt_mem #(
    parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(2*LEAVES)-1:0]      wr_addr,
    input  logic [rarmt_pkg::NODE_W-1:0]     wr_data,
    input  logic [$clog2(2*LEAVES)-1:0]      rd_addr,
    output logic [rarmt_pkg::NODE_W-1:0]     rd_data
);
    import rarmt_pkg::*;

    localparam int DEPTH = 2 * LEAVES;

    logic [NODE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/core/rarmt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarmt_seq
// Tree walk sequencer: depth-first visit of nodes with an explicit frame
// stack, read-modify-write of the node store, and the post-reset clear.
// ----------------------------------------------------------------------------
module rarmt_seq #(
    parameter int LEAVES = rarmt_pkg::LEAVES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rarmt_pkg::OP_W-1:0]       in_op,
    input  logic [rarmt_pkg::IDX_W-1:0]      in_left,
    input  logic [rarmt_pkg::IDX_W-1:0]      in_right,
    input  logic [rarmt_pkg::VAL_W-1:0]      in_value,
    // result
    input  logic                             out_free,
    output logic                             res_load,
    output logic [rarmt_pkg::MAX_W-1:0]      res_max,
    output logic                             res_empty,
    // node store
    output logic                             wr_en,
    output logic [$clog2(2*LEAVES)-1:0]      wr_addr,
    output logic [rarmt_pkg::NODE_W-1:0]     wr_data,
    output logic [$clog2(2*LEAVES)-1:0]      rd_addr,
    input  logic [rarmt_pkg::NODE_W-1:0]     rd_data
);
    import rarmt_pkg::*;

    localparam int NW   = $clog2(2 * LEAVES);
    localparam int LVLS = $clog2(LEAVES) + 1;
    localparam int SPW  = $clog2(LVLS);
    localparam int CW   = ($clog2(LEAVES) + 1 > IDX_W) ? $clog2(LEAVES) + 1 : IDX_W;
    localparam logic [CW-1:0]  LEAVES_C = CW'(LEAVES);
    localparam logic [SPW-1:0] SP_TOP   = SPW'(LVLS - 1);

    seq_state_t state_reg, state_next;
    logic [SPW-1:0]   sp_reg, sp_next;
    logic [NW-1:0]    clr_reg, clr_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [CW-1:0]    l_reg, l_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [MAX_W-1:0] vin_reg, vin_next;
    logic [MAX_W-1:0] vadd_reg, vadd_next;
    logic             add_reg, add_next;
    logic             raise_reg, raise_next;
    logic [MAX_W-1:0] ret_reg, ret_next;
    logic             retv_reg, retv_next;
    logic [MAX_W-1:0] rmax_reg, rmax_next;
    logic             remp_reg, remp_next;

    // frame stack
    logic [NW-1:0]    fu_reg  [LVLS];
    logic [CW-1:0]    fa_reg  [LVLS];
    logic [SPW-1:0]   fl_reg  [LVLS];
    logic             fph_reg [LVLS];
    logic [MAX_W-1:0] fr1_reg [LVLS];
    logic             fr1v_reg[LVLS];

    logic             push_en;
    logic [SPW-1:0]   push_idx;
    logic [NW-1:0]    push_u;
    logic [CW-1:0]    push_a;
    logic [SPW-1:0]   push_l;
    logic             upd_en;

    // current frame fields
    logic [NW-1:0]    cur_u;
    logic [CW-1:0]    cur_a, cur_b, cur_size, cur_half;
    logic [SPW-1:0]   cur_l;
    logic [MAX_W-1:0] node_pend, node_best, m12;
    logic             disjoint, covered;
    logic [CW-1:0]    in_l, in_r;
    logic [MAX_W-1:0] in_v;

    assign cur_u     = fu_reg[sp_reg];
    assign cur_a     = fa_reg[sp_reg];
    assign cur_l     = fl_reg[sp_reg];
    assign cur_size  = LEAVES_C >> cur_l;
    assign cur_half  = (LEAVES_C >> 1) >> cur_l;
    assign cur_b     = cur_a + cur_size;
    assign node_pend = rd_data[NODE_W-1:MAX_W];
    assign node_best = rd_data[MAX_W-1:0];
    assign disjoint  = (cur_b <= l_reg) || (r_reg <= cur_a);
    assign covered   = (l_reg <= cur_a) && (cur_b <= r_reg);
    assign m12       = smax(fr1_reg[sp_reg], ret_reg);
    assign in_l      = CW'(in_left);
    assign in_r      = (CW'(in_right) > LEAVES_C) ? LEAVES_C : CW'(in_right);
    assign in_v      = {{(MAX_W-VAL_W){in_value[VAL_W-1]}}, in_value};

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_max   = rmax_reg;
    assign res_empty = remp_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sp_reg    <= '0;
            clr_reg   <= '0;
            raise_reg <= 1'b0;
            add_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            clr_reg   <= clr_next;
            raise_reg <= raise_next;
            add_reg   <= add_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        vin_reg  <= vin_next;
        vadd_reg <= vadd_next;
        ret_reg  <= ret_next;
        retv_reg <= retv_next;
        rmax_reg <= rmax_next;
        remp_reg <= remp_next;
    end

    // frame stack writes
    always_ff @(posedge aclk) begin
        if (push_en) begin
            fu_reg[push_idx]  <= push_u;
            fa_reg[push_idx]  <= push_a;
            fl_reg[push_idx]  <= push_l;
            fph_reg[push_idx] <= 1'b0;
        end
        if (upd_en) begin
            fph_reg[sp_reg]  <= 1'b1;
            fr1_reg[sp_reg]  <= ret_reg;
            fr1v_reg[sp_reg] <= retv_reg;
        end
    end

    // next state and outputs
    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        vin_next   = vin_reg;
        vadd_next  = vadd_reg;
        add_next   = add_reg;
        raise_next = raise_reg;
        ret_next   = ret_reg;
        retv_next  = retv_reg;
        rmax_next  = rmax_reg;
        remp_next  = remp_reg;
        push_en    = 1'b0;
        push_idx   = SPW'(sp_reg + 1'b1);
        push_u     = NW'({cur_u, 1'b1});
        push_a     = cur_a;
        push_l     = SPW'(cur_l + 1'b1);
        upd_en     = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = cur_u;
        wr_data    = rd_data;
        rd_addr    = cur_u;
        res_load   = 1'b0;

        case (state_reg)
            // zero the node store after reset
            ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = NW'(clr_reg + 1'b1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end

            // take a request and decode it
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = in_op;
                    l_next     = in_l;
                    r_next     = in_r;
                    vin_next   = in_v;
                    vadd_next  = in_v;
                    raise_next = 1'b0;
                    rmax_next  = '0;
                    remp_next  = 1'b0;
                    sp_next    = '0;
                    push_idx   = '0;
                    push_u     = '0;
                    push_a     = '0;
                    push_l     = '0;
                    state_next = ST_DONE;
                    case (in_op)
                        OP_ADD: begin
                            if (in_l < in_r) begin
                                add_next   = 1'b1;
                                push_en    = 1'b1;
                                state_next = ST_CALL;
                            end
                        end
                        OP_QUERY: begin
                            if (in_l < in_r) begin
                                add_next   = 1'b0;
                                push_en    = 1'b1;
                                state_next = ST_CALL;
                            end else begin
                                rmax_next = EMPTY_VAL;
                                remp_next = 1'b1;
                            end
                        end
                        OP_RAISE: begin
                            if (in_l < LEAVES_C) begin
                                r_next     = CW'(in_l + 1'b1);
                                add_next   = 1'b0;
                                raise_next = 1'b1;
                                push_en    = 1'b1;
                                state_next = ST_CALL;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // read the node of the current frame
            ST_CALL: begin
                state_next = ST_EVAL;
            end

            // classify the node against the range
            ST_EVAL: begin
                if (disjoint) begin
                    ret_next   = node_best + node_pend;
                    retv_next  = 1'b0;
                    state_next = ST_RET;
                end else if (covered) begin
                    retv_next  = 1'b1;
                    state_next = ST_RET;
                    if (add_reg) begin
                        wr_en    = 1'b1;
                        wr_data  = {node_pend + vadd_reg, node_best};
                        ret_next = node_best + node_pend + vadd_reg;
                    end else begin
                        ret_next = node_best + node_pend;
                    end
                end else begin
                    push_en    = 1'b1;
                    sp_next    = push_idx;
                    state_next = ST_CALL;
                end
            end

            // pop back to the parent, or finish at the root
            ST_RET: begin
                if (sp_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    sp_next    = SPW'(sp_reg - 1'b1);
                    state_next = ST_RET2;
                end
            end

            // second child next, or combine after both
            ST_RET2: begin
                if (!fph_reg[sp_reg]) begin
                    upd_en     = 1'b1;
                    push_en    = 1'b1;
                    push_u     = NW'({cur_u, 1'b0} + 2'd2);
                    push_a     = cur_a + cur_half;
                    sp_next    = push_idx;
                    state_next = ST_CALL;
                end else begin
                    state_next = ST_PEVAL;
                end
            end

            // combine children and fold in this node's pending add
            ST_PEVAL: begin
                state_next = ST_RET;
                if (add_reg) begin
                    wr_en    = 1'b1;
                    wr_data  = {node_pend, m12};
                    ret_next = m12 + node_pend;
                end else begin
                    retv_next = fr1v_reg[sp_reg] || retv_reg;
                    if (fr1v_reg[sp_reg] && retv_reg) begin
                        ret_next = m12 + node_pend;
                    end else if (fr1v_reg[sp_reg]) begin
                        ret_next = fr1_reg[sp_reg] + node_pend;
                    end else begin
                        ret_next = ret_reg + node_pend;
                    end
                end
            end

            // end of a walk
            ST_FIN: begin
                state_next = ST_DONE;
                if (raise_reg) begin
                    raise_next = 1'b0;
                    if (retv_reg && sgt(vin_reg, ret_reg)) begin
                        add_next   = 1'b1;
                        vadd_next  = vin_reg - ret_reg;
                        sp_next    = '0;
                        push_en    = 1'b1;
                        push_idx   = '0;
                        push_u     = '0;
                        push_a     = '0;
                        push_l     = '0;
                        state_next = ST_CALL;
                    end
                end else if (op_reg == OP_QUERY) begin
                    if (retv_reg) begin
                        rmax_next = ret_reg;
                    end else begin
                        rmax_next = EMPTY_VAL;
                        remp_next = 1'b1;
                    end
                end
            end

            // hand the result to the output register
            ST_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stack never grows past the leaf level
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_TOP)
        else $error("frame stack overflow");

    // a query walk never writes the node store
    a_query_ro: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR && !add_reg) |-> !wr_en)
        else $error("node write during query");

    // an accepted request always leaves idle
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("request dropped");

endmodule

FILE: tb/range_add_range_max_tree_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_max_tree_tb
// Drives random and directed range add, range max and point raise beats into
// the segment tree and checks every result against a flat array of leaves.
// ----------------------------------------------------------------------------

// expected results and a flat copy of the leaf values
class tree_scoreboard;
    localparam int NLEAF = rarmt_pkg::LEAVES_DEF;

    logic [63:0] leaf_val [NLEAF];
    logic [63:0] exp_max [$];
    logic        exp_empty [$];
    int          errors;

    function new();
        foreach (leaf_val[i]) leaf_val[i] = '0;
        errors = 0;
    endfunction

    // accepted input beat: update leaves, queue result
    function void note_beat(logic [1:0] op, logic [10:0] lo, logic [10:0] hi,
                            logic [47:0] val);
        logic [63:0] sv;
        logic [63:0] best;
        int          r;
        bit          found;
        sv = {{16{val[47]}}, val};
        r = (hi > NLEAF) ? NLEAF : hi;
        best = '0;
        found = 0;
        if (op == rarmt_pkg::OP_ADD) begin
            for (int i = lo; i < r; i++) leaf_val[i] = leaf_val[i] + sv;
        end else if (op == rarmt_pkg::OP_QUERY) begin
            for (int i = lo; i < r; i++) begin
                if (!found || $signed(leaf_val[i]) > $signed(best)) best = leaf_val[i];
                found = 1;
            end
        end else if (op == rarmt_pkg::OP_RAISE) begin
            if (lo < NLEAF && $signed(sv) > $signed(leaf_val[lo])) leaf_val[lo] = sv;
        end
        if (op == rarmt_pkg::OP_QUERY && !found) begin
            exp_max.push_back(rarmt_pkg::EMPTY_VAL);
            exp_empty.push_back(1'b1);
        end else begin
            exp_max.push_back(best);
            exp_empty.push_back(1'b0);
        end
    endfunction

    function void check_result(logic [63:0] mx, logic em);
        logic [63:0] e_mx;
        logic        e_em;
        if (exp_max.size() == 0) begin
            $display("%0t: unexpected result max=%h empty=%b", $time, mx, em);
            errors++;
            return;
        end
        e_mx = exp_max.pop_front();
        e_em = exp_empty.pop_front();
        if (mx !== e_mx) begin
            $display("%0t: max_value mismatch exp=%h act=%h", $time, e_mx, mx);
            errors++;
        end
        if (em !== e_em) begin
            $display("%0t: empty_range mismatch exp=%b act=%b", $time, e_em, em);
            errors++;
        end
    endfunction

    function int pending();
        return exp_max.size();
    endfunction
endclass

module range_add_range_max_tree_tb;
    import rarmt_pkg::*;

    localparam int NLEAF = LEAVES_DEF;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    tree_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  recv_hold = 0;

    range_add_range_max_tree #(.LEAVES(NLEAF)) dut (.*);

    // clock
    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // hold off the receiver for a long stretch
    task automatic hold_receiver(int cycles);
        recv_hold = 1;
        repeat (cycles) @(posedge aclk);
        recv_hold = 0;
    endtask

    // offer one beat and wait until it is taken
    task automatic send_beat(logic [1:0] op, logic [10:0] lo, logic [10:0] hi,
                             logic [47:0] val);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {val, hi, lo, op};
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(op, lo, hi, val);
        s_tvalid <= 1'b0;
        // the block is busy after it takes a beat
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // random beat: mostly small spans, some wide, clipped or empty ranges
    task automatic send_random();
        logic [1:0]  op;
        logic [10:0] lo, hi;
        logic [47:0] val;
        int          sel;
        op = 2'($urandom_range(2));
        sel = $urandom_range(9);
        lo = 11'($urandom_range(NLEAF - 1));
        if (sel < 6) hi = 11'(lo + $urandom_range(40));
        else if (sel < 8) hi = 11'($urandom_range(2047));
        else begin
            lo = 11'($urandom_range(2047));
            hi = 11'($urandom_range(2047));
        end
        if (op == OP_RAISE && $urandom_range(9) == 0) lo = 11'(NLEAF + $urandom_range(1023));
        case ($urandom_range(3))
            0: val = 48'({$urandom, $urandom});
            1: val = 48'($signed(32'($urandom_range(2000))) - 1000);
            2: val = 48'({1'b0, {47{1'b1}}} - $urandom_range(3));
            default: val = 48'({1'b1, 47'd0} + $urandom_range(3));
        endcase
        if ($urandom_range(19) == 0) op = OP_UNUSED;
        send_beat(op, lo, hi, val);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every op, empty and clipped ranges
        send_beat(OP_QUERY, 11'd0, 11'd1024, 48'd0);
        send_beat(OP_QUERY, 11'd5, 11'd5, 48'd0);
        send_beat(OP_QUERY, 11'd9, 11'd3, 48'd0);
        send_beat(OP_ADD, 11'd0, 11'd1024, 48'h7FFF_FFFF_FFFF);
        send_beat(OP_ADD, 11'd0, 11'd2047, 48'h7FFF_FFFF_FFFF);
        send_beat(OP_ADD, 11'd7, 11'd7, 48'h1234);
        send_beat(OP_QUERY, 11'd0, 11'd2047, 48'd0);
        send_beat(OP_ADD, 11'd1023, 11'd1024, 48'h8000_0000_0000);
        send_beat(OP_QUERY, 11'd1023, 11'd2047, 48'd0);
        send_beat(OP_RAISE, 11'd0, 11'd0, 48'h7FFF_FFFF_FFFF);
        send_beat(OP_RAISE, 11'd0, 11'd0, 48'h8000_0000_0000);
        send_beat(OP_RAISE, 11'd2047, 11'd0, 48'h7FFF_FFFF_FFFF);
        send_beat(OP_RAISE, 11'd1024, 11'd0, 48'h1);
        send_beat(OP_UNUSED, 11'd2047, 11'd2047, 48'hFFFF_FFFF_FFFF);
        send_beat(OP_QUERY, 11'd0, 11'd1, 48'd0);
        send_beat(OP_QUERY, 11'd1024, 11'd2047, 48'd0);
        for (int k = 0; k < 6; k++) send_beat(OP_ADD, 11'd0, 11'd1024, 48'h8000_0000_0000);
        send_beat(OP_QUERY, 11'd100, 11'd900, 48'd0);
        send_beat(OP_QUERY, 11'd0, 11'd1024, 48'd0);

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 86 : 28) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 86 : 28) : 0;
            for (int n = 0; n < 120; n++) send_random();
            // sender pauses until all results are in
            wait_drained();
        end

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            hold_receiver(2000);
            for (int n = 0; n < 20; n++) send_random();
        join

        wait_drained();
        repeat (300) @(posedge aclk);
        if (sb.errors == 0)
            $display("** range_add_range_max_tree: PASSED **");
        else
            $display("** range_add_range_max_tree: FAILED **");
        $finish;
    end

    // run time limit
    initial begin
        #20ms;
        $display("** range_add_range_max_tree: FAILED **");
        $finish;
    end
endmodule
